// ===== sv/scdv_pkg.sv =====
// Shared types and codes for the saved-record chunk deframer and verifier.
// Used by scdv_ctrl and the top level save_chunk_deframer_verifier; depends on nothing.
package scdv_pkg;

    typedef enum logic [1:0] {
        FN_BEGIN    = 2'd0,
        FN_DATA     = 2'd1,
        FN_END      = 2'd2,
        FN_READ_ERR = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_READ_FAIL = 3'd1,
        ST_BAD_HDR   = 3'd2,
        ST_TOO_NEW   = 3'd3,
        ST_BAD_COUNT = 3'd4,
        ST_TOO_LONG  = 3'd5,
        ST_SHORT     = 3'd6,
        ST_CHECKSUM  = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        CFG_SAVE_SLOT     = 2'd0,
        CFG_MAX_BYTES     = 2'd1,
        CFG_KNOWN_VERSION = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HEAD = 3'b010,
        PH_REST = 3'b100
    } t_phase;

    localparam logic [7:0]  MAGIC_0       = 8'h50;  // 'P'
    localparam logic [7:0]  MAGIC_1       = 8'h53;  // 'S'
    localparam logic [15:0] CHECKSUM_SEED = 16'h5A5A;
    localparam logic [9:0]  MAX_BYTES_RST = 10'd1016;
    localparam int          HEADER_BYTES  = 8;

    typedef struct packed {
        logic [7:0] chunk_key;
        logic       key_valid;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic [9:0] byte_offset;
        logic       done_res;
        t_status    status;
        logic [9:0] payload_length;
        logic [7:0] rec_version;
    } t_result;

endpackage

// ===== sv/save_chunk_deframer_verifier.sv =====
// Top level of the saved-record chunk deframer and verifier: stream ports and output buffer.
// Instantiates scdv_ctrl; depends on scdv_pkg.
//
// The block takes one input beat per clock cycle while s_axis_tready is high. Its result,
// if it has one, is registered in the output buffer. A two-entry output buffer (result
// register plus skid register) sits in front of the master port, so input beats keep
// flowing while one result waits; s_axis_tready drops only when both entries are full.
// Header parsing, the payload offset and the rotate-and-add checksum update all complete
// in the cycle a beat is accepted. There is no clearing pass after reset.
module save_chunk_deframer_verifier #(
    parameter int KEY_BYTES     = 64,
    parameter int SLOT_CHUNKS   = 16,
    parameter int MAX_PAYLOAD   = 1016,
    parameter int KEY_BASE      = 0,
    parameter int FIRST_PAYLOAD = 56
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // chunk_key[7:0], payload_byte[15:8], byte_offset[25:16], status[28:26],
    // payload_length[38:29], rec_version[46:39], zero[47]
    output logic [47:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // key_valid[0], byte_valid[1], done_res[2]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [9:0]  i_cfg_wdata
);

    logic              accept;
    logic              has_result;
    scdv_pkg::t_result result;

    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    scdv_pkg::t_result r_out, n_out;
    scdv_pkg::t_result r_skid, n_skid;
    logic              push, pop;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept && has_result;
    assign pop           = r_out_valid && m_axis_tready;

    scdv_ctrl #(
        .KEY_BYTES    (KEY_BYTES),
        .SLOT_CHUNKS  (SLOT_CHUNKS),
        .MAX_PAYLOAD  (MAX_PAYLOAD),
        .KEY_BASE     (KEY_BASE),
        .FIRST_PAYLOAD(FIRST_PAYLOAD)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_func      (s_axis_tuser),
        .i_data_byte (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_has_result(has_result),
        .o_result    (result)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                // The skid entry is older; no push can happen while it is full.
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = result;
                n_out_valid = push;
            end
        end else if (push) begin
            n_skid       = result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.rec_version, r_out.payload_length,
                            r_out.status, r_out.byte_offset, r_out.payload_byte,
                            r_out.chunk_key};
    assign m_axis_tuser  = {r_out.done_res, r_out.byte_valid, r_out.key_valid};

endmodule

// ===== sv/scdv_ctrl.sv =====
// Load sequencer: configuration registers, header parser, payload offsets and checksum.
// Computes the result of one accepted beat; depends on scdv_pkg.
module scdv_ctrl #(
    parameter int KEY_BYTES     = 64,
    parameter int SLOT_CHUNKS   = 16,
    parameter int MAX_PAYLOAD   = 1016,
    parameter int KEY_BASE      = 0,
    parameter int FIRST_PAYLOAD = 56
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_func,
    input  logic [7:0]       i_data_byte,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [9:0]       i_cfg_wdata,
    output logic             o_has_result,
    output scdv_pkg::t_result o_result
);

    localparam int PW = $clog2(KEY_BYTES + 1);

    logic [3:0]        r_slot;
    logic [9:0]        r_max_bytes;
    logic [7:0]        r_known_version;

    scdv_pkg::t_phase  r_phase, n_phase;
    logic [4:0]        r_idx, n_idx;
    logic [PW-1:0]     r_pos, n_pos;
    logic [7:0]        r_version, n_version;
    logic [7:0]        r_chunks, n_chunks;
    logic [15:0]       r_length, n_length;
    logic [15:0]       r_hdr_cs, n_hdr_cs;
    logic [15:0]       r_cs, n_cs;
    logic [10:0]       r_rcv, n_rcv;

    logic [5:0]        next_idx;
    logic [4:0]        key_chunk;
    logic [7:0]        key_val;
    logic [15:0]       hdr_cs_full;
    logic              sum_ok;

    assign next_idx    = {1'b0, r_idx} + 6'd1;
    assign hdr_cs_full = {i_data_byte, r_hdr_cs[7:0]};
    assign sum_ok      = (r_cs == r_hdr_cs);
    assign key_val     = 8'(16'(KEY_BASE) + 16'(r_slot) * 16'(SLOT_CHUNKS)
                            + 16'(key_chunk));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot          <= '0;
            r_max_bytes     <= scdv_pkg::MAX_BYTES_RST;
            r_known_version <= '0;
        end else if (i_cfg_we) begin
            unique case (scdv_pkg::t_cfg_index'(i_cfg_addr))
                scdv_pkg::CFG_SAVE_SLOT:     r_slot          <= i_cfg_wdata[3:0];
                scdv_pkg::CFG_MAX_BYTES:     r_max_bytes     <= i_cfg_wdata;
                scdv_pkg::CFG_KNOWN_VERSION: r_known_version <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_version    = r_version;
        n_chunks     = r_chunks;
        n_length     = r_length;
        n_hdr_cs     = r_hdr_cs;
        n_cs         = r_cs;
        n_rcv        = r_rcv;
        key_chunk    = '0;
        o_has_result = 1'b0;
        o_result     = '0;

        if (scdv_pkg::t_func'(i_func) == scdv_pkg::FN_BEGIN) begin
            n_phase   = scdv_pkg::PH_HEAD;
            n_idx     = '0;
            n_pos     = '0;
            n_version = '0;
            n_chunks  = '0;
            n_length  = '0;
            n_hdr_cs  = '0;
            n_cs      = scdv_pkg::CHECKSUM_SEED;
            n_rcv     = '0;
            o_has_result       = 1'b1;
            o_result.chunk_key = key_val;
            o_result.key_valid = 1'b1;
        end else if (r_phase != scdv_pkg::PH_IDLE) begin
            // Any done result carries the version seen so far; fields set below refine it.
            o_result.rec_version = r_version;
            unique case (scdv_pkg::t_func'(i_func))
                scdv_pkg::FN_READ_ERR: begin
                    o_has_result     = 1'b1;
                    o_result.done_res = 1'b1;
                    o_result.status  = scdv_pkg::ST_READ_FAIL;
                    n_phase          = scdv_pkg::PH_IDLE;
                end
                scdv_pkg::FN_END: begin
                    o_has_result = 1'b1;
                    if (r_phase == scdv_pkg::PH_HEAD
                            && r_pos < PW'(scdv_pkg::HEADER_BYTES)) begin
                        o_result.done_res = 1'b1;
                        o_result.status   = scdv_pkg::ST_BAD_HDR;
                        n_phase           = scdv_pkg::PH_IDLE;
                    end else if ({2'b00, next_idx} < r_chunks) begin
                        n_idx              = next_idx[4:0];
                        n_pos              = '0;
                        n_phase            = scdv_pkg::PH_REST;
                        key_chunk          = next_idx[4:0];
                        o_result.chunk_key = key_val;
                        o_result.key_valid = 1'b1;
                        o_result.rec_version = '0;
                    end else begin
                        o_result.done_res = 1'b1;
                        n_phase           = scdv_pkg::PH_IDLE;
                        if ({5'b0, r_rcv} != r_length) begin
                            o_result.status = scdv_pkg::ST_SHORT;
                        end else if (!sum_ok) begin
                            o_result.status = scdv_pkg::ST_CHECKSUM;
                        end else begin
                            o_result.status         = scdv_pkg::ST_OK;
                            o_result.payload_length = r_length[9:0];
                        end
                    end
                end
                scdv_pkg::FN_DATA: begin
                    if (r_pos < PW'(KEY_BYTES)) begin
                        n_pos = r_pos + PW'(1);
                        if (r_phase == scdv_pkg::PH_HEAD
                                && r_pos < PW'(scdv_pkg::HEADER_BYTES)) begin
                            unique case (r_pos[2:0])
                                3'd0: if (i_data_byte != scdv_pkg::MAGIC_0) begin
                                    o_has_result      = 1'b1;
                                    o_result.done_res = 1'b1;
                                    o_result.status   = scdv_pkg::ST_BAD_HDR;
                                    n_phase           = scdv_pkg::PH_IDLE;
                                end
                                3'd1: if (i_data_byte != scdv_pkg::MAGIC_1) begin
                                    o_has_result      = 1'b1;
                                    o_result.done_res = 1'b1;
                                    o_result.status   = scdv_pkg::ST_BAD_HDR;
                                    n_phase           = scdv_pkg::PH_IDLE;
                                end
                                3'd2: n_version = i_data_byte;
                                3'd3: n_chunks  = i_data_byte;
                                3'd4: n_length  = {8'h00, i_data_byte};
                                3'd5: n_length  = {i_data_byte, r_length[7:0]};
                                3'd6: n_hdr_cs  = {8'h00, i_data_byte};
                                default: begin
                                    n_hdr_cs = hdr_cs_full;
                                    priority if (r_version > r_known_version) begin
                                        o_has_result      = 1'b1;
                                        o_result.done_res = 1'b1;
                                        o_result.status   = scdv_pkg::ST_TOO_NEW;
                                        n_phase           = scdv_pkg::PH_IDLE;
                                    end else if (r_chunks == 8'd0
                                            || r_chunks > 8'(SLOT_CHUNKS)) begin
                                        o_has_result      = 1'b1;
                                        o_result.done_res = 1'b1;
                                        o_result.status   = scdv_pkg::ST_BAD_COUNT;
                                        n_phase           = scdv_pkg::PH_IDLE;
                                    end else if (r_length > 16'(MAX_PAYLOAD)
                                            || r_length > {6'b0, r_max_bytes}) begin
                                        o_has_result      = 1'b1;
                                        o_result.done_res = 1'b1;
                                        o_result.status   = scdv_pkg::ST_TOO_LONG;
                                        n_phase           = scdv_pkg::PH_IDLE;
                                    end else begin
                                        n_phase = r_phase;
                                    end
                                end
                            endcase
                        end else if ({5'b0, r_rcv} < r_length
                                && !(r_phase == scdv_pkg::PH_HEAD
                                     && r_rcv >= 11'(FIRST_PAYLOAD))) begin
                            o_has_result          = 1'b1;
                            o_result.payload_byte = i_data_byte;
                            o_result.byte_valid   = 1'b1;
                            o_result.byte_offset  = r_rcv[9:0];
                            n_cs  = {r_cs[14:0], r_cs[15]} + {8'h00, i_data_byte};
                            n_rcv = r_rcv + 11'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= scdv_pkg::PH_IDLE;
            r_idx     <= '0;
            r_pos     <= '0;
            r_version <= '0;
            r_chunks  <= '0;
            r_length  <= '0;
            r_hdr_cs  <= '0;
            r_cs      <= scdv_pkg::CHECKSUM_SEED;
            r_rcv     <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_pos     <= n_pos;
            r_version <= n_version;
            r_chunks  <= n_chunks;
            r_length  <= n_length;
            r_hdr_cs  <= n_hdr_cs;
            r_cs      <= n_cs;
            r_rcv     <= n_rcv;
        end
    end

endmodule
